// File: src/rau_pkg.sv
package rau_pkg;

  // Operation codes carried in the kind field.
  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_EQ  = 3'd4;

endpackage

// File: src/rau_div.sv
module rau_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder,
  output logic         done
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_sub;
  logic          take;

  // One restoring step: bring down the next dividend bit and try the subtract.
  always_comb begin
    rem_sh  = {remainder, quotient[W-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    take    = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient  <= dividend;
        remainder <= '0;
        cnt       <= CW'(W);
      end else if (cnt != '0) begin
        quotient  <= {quotient[W-2:0], take};
        remainder <= take ? rem_sub[W-1:0] : rem_sh[W-1:0];
        cnt       <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/rau_mul.sv
module rau_mul #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] op_a,
  input  logic [W-1:0] op_b,
  output logic [W-1:0] product,
  output logic         done
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  ma;
  logic [W-1:0]  mb;

  // Shift and add, one multiplier bit a cycle, keeping the low W bits only.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        product <= '0;
        ma      <= op_a;
        mb      <= op_b;
        cnt     <= CW'(W);
      end else if (cnt != '0) begin
        if (mb[0]) begin
          product <= product + ma;
        end
        ma  <= {ma[W-2:0], 1'b0};
        mb  <= {1'b0, mb[W-1:1]};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/rational_arithmetic_unit.sv
// Rational arithmetic unit.
// Input channel s_*: one transaction carries an operation code in s_tuser and
// two fractions in s_tdata. Output channel m_*: one transaction per input,
// the reduced result in m_tdata with the equality and fault flags in m_tuser.
// The operations share one bit-serial divider and one bit-serial
// multiplier. The Euclidean gcd loop needs one divider pass per remainder
// step, which depends on the data.
// Multiply takes two multiplier passes and one reduction; add and subtract
// take a gcd, three multiplier and three divider passes plus a reduction.
// A reduction is one gcd plus two divider passes.
// The input is taken only while the sequencer is idle, one item at a time; a
// result waiting in the output register does not stop the next item from
// being accepted, but the sequencer holds its finished result until the
// output register is free, so a stalled receiver loses nothing.
// Reset is synchronous and returns the sequencer to idle with no result
// pending.
module rational_arithmetic_unit #(
  parameter int PART_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // left_num, left_den, right_num, right_den (lowest bits first)
  input  logic [127:0] s_tdata,
  // kind
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_num, out_den (lowest bits first)
  output logic [63:0]  m_tdata,
  // is_equal, fault (lowest bit first)
  output logic [1:0]   m_tuser
);

  import rau_pkg::*;

  localparam int W = PART_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_WAIT,
    G_STEP, G_REM,
    R_START, R_G, R_N, R_D,
    A_G, A_P, A_L, A_Q1, A_T1, A_Q2, A_T2,
    M_1, M_2,
    D_1, D_2, D_3,
    E_1, E_2,
    S_FINISH
  } state_t;

  state_t state, ret, gret, rret;

  logic [2:0]   kind;
  logic [W-1:0] na, da, nb, db;
  logic [W-1:0] rn, rd, an, ad, l, ta, gx, gy;
  logic         fault, is_eq, qneg;

  logic         mul_start, div_start, mul_done, div_done;
  logic [W-1:0] mul_a, mul_b, mul_p, div_a, div_b, div_q, div_r, fixq;

  function automatic logic [W-1:0] neg_w(input logic [W-1:0] x);
    return '0 - x;
  endfunction

  function automatic logic [W-1:0] mag_w(input logic [W-1:0] x);
    return x[W-1] ? ('0 - x) : x;
  endfunction

  rau_mul #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
    .product(mul_p), .done(mul_done)
  );

  rau_div #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .quotient(div_q), .remainder(div_r), .done(div_done)
  );

  // Quotient with the sign of the pending signed division applied.
  assign fixq     = qneg ? neg_w(div_q) : div_q;
  assign s_tready = (state == S_IDLE);

  // Sequencer: a step that issues a pass of a shared unit also names the
  // step that takes its result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      // The finishing step reloads the output register itself.
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind  <= s_tuser;
            na    <= W'($signed(s_tdata[31:0]));
            da    <= W'($signed(s_tdata[63:32]));
            nb    <= W'($signed(s_tdata[95:64]));
            db    <= W'($signed(s_tdata[127:96]));
            fault <= 1'b0;
            is_eq <= 1'b0;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (kind)
            KIND_ADD, KIND_SUB: begin
              gx    <= mag_w(da);
              gy    <= mag_w(db);
              gret  <= A_G;
              state <= G_STEP;
            end
            KIND_MUL: begin
              mul_a     <= na;
              mul_b     <= nb;
              mul_start <= 1'b1;
              ret       <= M_1;
              state     <= S_WAIT;
            end
            KIND_DIV: begin
              rn    <= db;
              rd    <= nb;
              rret  <= D_1;
              state <= R_START;
            end
            KIND_EQ: begin
              rn    <= na;
              rd    <= da;
              rret  <= E_1;
              state <= R_START;
            end
            default: state <= S_FINISH;
          endcase
        end
        S_WAIT: begin
          if (mul_done || div_done) begin
            state <= ret;
          end
        end
        // Euclidean gcd of gx and gy, result left in gx.
        G_STEP: begin
          if (gy == '0) begin
            state <= gret;
          end else begin
            div_a     <= gx;
            div_b     <= gy;
            div_start <= 1'b1;
            ret       <= G_REM;
            state     <= S_WAIT;
          end
        end
        G_REM: begin
          gx    <= gy;
          gy    <= div_r;
          state <= G_STEP;
        end
        // Reduction of rn/rd in place.
        R_START: begin
          gx    <= mag_w(rn);
          gy    <= mag_w(rd);
          gret  <= R_G;
          state <= G_STEP;
        end
        R_G: begin
          if (gx == '0) begin
            fault <= 1'b1;
            state <= S_FINISH;
          end else begin
            div_a     <= mag_w(rn);
            div_b     <= gx;
            qneg      <= rn[W-1];
            div_start <= 1'b1;
            ret       <= R_N;
            state     <= S_WAIT;
          end
        end
        R_N: begin
          rn        <= fixq;
          div_a     <= mag_w(rd);
          div_b     <= gx;
          qneg      <= rd[W-1];
          div_start <= 1'b1;
          ret       <= R_D;
          state     <= S_WAIT;
        end
        R_D: begin
          if (rn[W-1] && fixq[W-1]) begin
            rn <= neg_w(rn);
            rd <= neg_w(fixq);
          end else begin
            rd <= fixq;
          end
          state <= rret;
        end
        // Add and subtract over the least common multiple.
        A_G: begin
          if (gx == '0 || da == '0 || db == '0) begin
            fault <= 1'b1;
            state <= S_FINISH;
          end else begin
            mul_a     <= da;
            mul_b     <= db;
            mul_start <= 1'b1;
            ret       <= A_P;
            state     <= S_WAIT;
          end
        end
        A_P: begin
          div_a     <= mag_w(mul_p);
          div_b     <= gx;
          qneg      <= mul_p[W-1];
          div_start <= 1'b1;
          ret       <= A_L;
          state     <= S_WAIT;
        end
        A_L: begin
          l         <= fixq;
          div_a     <= mag_w(fixq);
          div_b     <= mag_w(da);
          qneg      <= fixq[W-1] ^ da[W-1];
          div_start <= 1'b1;
          ret       <= A_Q1;
          state     <= S_WAIT;
        end
        A_Q1: begin
          mul_a     <= na;
          mul_b     <= fixq;
          mul_start <= 1'b1;
          ret       <= A_T1;
          state     <= S_WAIT;
        end
        A_T1: begin
          ta        <= mul_p;
          div_a     <= mag_w(l);
          div_b     <= mag_w(db);
          qneg      <= l[W-1] ^ db[W-1];
          div_start <= 1'b1;
          ret       <= A_Q2;
          state     <= S_WAIT;
        end
        A_Q2: begin
          mul_a     <= nb;
          mul_b     <= fixq;
          mul_start <= 1'b1;
          ret       <= A_T2;
          state     <= S_WAIT;
        end
        A_T2: begin
          rn    <= (kind == KIND_ADD) ? (ta + mul_p) : (ta - mul_p);
          rd    <= l;
          rret  <= S_FINISH;
          state <= R_START;
        end
        // Multiply.
        M_1: begin
          rn        <= mul_p;
          mul_a     <= da;
          mul_b     <= db;
          mul_start <= 1'b1;
          ret       <= M_2;
          state     <= S_WAIT;
        end
        M_2: begin
          rd    <= mul_p;
          rret  <= S_FINISH;
          state <= R_START;
        end
        // Divide: the reduced, swapped divisor sits in rn/rd.
        D_1: begin
          mul_a     <= na;
          mul_b     <= rn;
          mul_start <= 1'b1;
          ret       <= D_2;
          state     <= S_WAIT;
        end
        D_2: begin
          rn        <= mul_p;
          mul_a     <= da;
          mul_b     <= rd;
          mul_start <= 1'b1;
          ret       <= D_3;
          state     <= S_WAIT;
        end
        D_3: begin
          rd    <= mul_p;
          rret  <= S_FINISH;
          state <= R_START;
        end
        // Equality test on both reduced operands.
        E_1: begin
          an    <= rn;
          ad    <= rd;
          rn    <= nb;
          rd    <= db;
          rret  <= E_2;
          state <= R_START;
        end
        E_2: begin
          is_eq <= (rn == an) && (rd == ad);
          state <= S_FINISH;
        end
        // Load the output register once it is free.
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (fault || kind == KIND_EQ || kind > KIND_EQ) begin
              m_tdata <= '0;
            end else begin
              m_tdata <= {32'($signed(rd)), 32'($signed(rn))};
            end
            m_tuser <= {fault, is_eq & ~fault};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: verif/tb_rational_arithmetic_unit.sv
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int RANDOM_ITEMS = 680;
  localparam int CYCLE_LIMIT  = 20000000;
  localparam int DRAIN_CYCLES = 2500;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        eq;
    logic        fault;
  } frac_result_t;

  typedef struct {
    logic [2:0]   kind;
    logic [31:0]  ln;
    logic [31:0]  ld;
    logic [31:0]  rn;
    logic [31:0]  rd;
    bit           typed;
    frac_result_t res;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;
  logic [1:0]   m_tuser;

  frac_result_t pending_results[$];
  int           mismatches = 0;
  int unsigned  cycle_count = 0;

  rational_arithmetic_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Clock generation.
  always #5 clk = ~clk;

  // Magnitude of a two's complement part, taken unsigned.
  function automatic logic [31:0] part_mag(logic [31:0] x);
    return x[31] ? -x : x;
  endfunction

  // Signed division by a divisor of magnitude m and sign dneg, truncating.
  function automatic logic [31:0] part_div(logic [31:0] x, logic [31:0] m, logic dneg);
    logic [31:0] q;
    q = part_mag(x) / m;
    return (x[31] != dneg) ? -q : q;
  endfunction

  // Euclidean gcd of the magnitudes.
  function automatic logic [31:0] part_gcd(logic [31:0] a, logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] t;
    x = part_mag(a);
    y = part_mag(b);
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Reduces n/d in place; returns 0 when the gcd is zero.
  function automatic bit reduce_frac(inout logic [31:0] n, inout logic [31:0] d);
    logic [31:0] g;
    g = part_gcd(n, d);
    if (g == 0) return 0;
    n = part_div(n, g, 1'b0);
    d = part_div(d, g, 1'b0);
    if (n[31] && d[31]) begin
      n = -n;
      d = -d;
    end
    return 1;
  endfunction

  // Expected result of one operation.
  function automatic frac_result_t predict_fraction(logic [2:0] kind, logic [31:0] na,
                                                    logic [31:0] da, logic [31:0] nb,
                                                    logic [31:0] db);
    frac_result_t r;
    logic [31:0]  g;
    logic [31:0]  l;
    logic [31:0]  ta;
    logic [31:0]  tb;
    logic [31:0]  an;
    logic [31:0]  ad;
    logic [31:0]  bn;
    logic [31:0]  bd;
    bit           ok;
    bit           oa;
    bit           ob;
    r  = '0;
    ok = 1;
    case (kind)
      KIND_ADD, KIND_SUB: begin
        g = part_gcd(da, db);
        if (g == 0 || da == 0 || db == 0) begin
          ok = 0;
        end else begin
          l  = part_div(da * db, g, 1'b0);
          ta = na * part_div(l, part_mag(da), da[31]);
          tb = nb * part_div(l, part_mag(db), db[31]);
          r.num = (kind == KIND_ADD) ? ta + tb : ta - tb;
          r.den = l;
          ok = reduce_frac(r.num, r.den);
        end
      end
      KIND_MUL: begin
        r.num = na * nb;
        r.den = da * db;
        ok = reduce_frac(r.num, r.den);
      end
      KIND_DIV: begin
        an = db;
        ad = nb;
        ok = reduce_frac(an, ad);
        if (ok) begin
          r.num = na * an;
          r.den = da * ad;
          ok = reduce_frac(r.num, r.den);
        end
      end
      KIND_EQ: begin
        an = na;
        ad = da;
        bn = nb;
        bd = db;
        oa = reduce_frac(an, ad);
        ob = reduce_frac(bn, bd);
        ok = oa && ob;
        r.eq = ok && an == bn && ad == bd;
      end
      default: ;
    endcase
    if (!ok) r = '0;
    r.fault = !ok;
    return r;
  endfunction

  // Random operand part: mostly small, some extremes, some full range.
  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'd0;
      3, 4:    return $urandom();
      5:       return $urandom_range(0, 65535) - 32768;
      default: return $urandom_range(0, 40) - 20;
    endcase
  endfunction

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rational_arithmetic_unit test failed");
      $finish;
    end
  end

  // Receiver stalls: mostly short, now and then long.
  initial begin : receiver
    int stall;
    m_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 5) == 0)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
      end
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    frac_result_t want;
    frac_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1]};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: num %h/%h den %h/%h eq %b/%b fault %b/%b (exp/act)",
                     want.num, got.num, want.den, got.den, want.eq, got.eq,
                     want.fault, got.fault);
        end
      end
    end
  end

  // Presents one item and holds it until the transaction completes.
  task automatic send_item(logic [2:0] kind, logic [31:0] ln, logic [31:0] ld,
                           logic [31:0] rn, logic [31:0] rd, frac_result_t res);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ?
          (($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(1, 5)) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rd, rn, ld, ln};
    s_tuser  <= kind;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    pending_results.push_back(res);
    @(negedge clk);
  endtask

  initial begin : stimulus
    stim_row_t   rows[$];
    stim_row_t   row;
    logic [2:0]  kind;
    logic [31:0] p[4];
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;

    // Directed rows; typed expectations where they are obvious.
    rows.push_back('{KIND_ADD, 32'd1, 32'd0, 32'd1, 32'd2, 1, '{0, 0, 0, 1}});
    rows.push_back('{KIND_SUB, 32'd3, 32'd4, 32'd1, 32'd0, 1, '{0, 0, 0, 1}});
    rows.push_back('{KIND_MUL, 32'd0, 32'd0, 32'd5, 32'd7, 1, '{0, 0, 0, 1}});
    rows.push_back('{KIND_EQ,  32'd0, 32'd0, 32'd1, 32'd1, 1, '{0, 0, 0, 1}});
    rows.push_back('{3'd5, 32'd1, 32'd2, 32'd3, 32'd4, 1, '{0, 0, 0, 0}});
    rows.push_back('{3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                     '{0, 0, 0, 0}});
    rows.push_back('{3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 1, '{0, 0, 0, 0}});
    rows.push_back('{KIND_EQ,  32'd2, 32'd4, 32'd1, 32'd2, 1, '{0, 0, 1, 0}});
    rows.push_back('{KIND_MUL, 32'd2, 32'd3, 32'd3, 32'd4, 1, '{1, 2, 0, 0}});
    rows.push_back('{KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 0, '0});
    rows.push_back('{KIND_SUB, 32'd1, 32'd2, 32'd1, 32'd3, 0, '0});
    rows.push_back('{KIND_DIV, 32'd1, 32'd2, 32'd3, 32'd4, 0, '0});
    rows.push_back('{KIND_DIV, 32'd1, 32'd1, 32'd0, 32'd1, 0, '0});
    rows.push_back('{KIND_DIV, 32'd1, 32'd1, 32'd0, 32'd0, 0, '0});
    rows.push_back('{KIND_ADD, 32'hFFFF_FFFD, 32'hFFFF_FFFC, 32'd5, 32'hFFFF_FFFA, 0, '0});
    rows.push_back('{KIND_MUL, 32'hFFFF_FFFF, 32'd2, 32'd1, 32'hFFFF_FFFD, 0, '0});
    rows.push_back('{KIND_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'd1, 0, '0});
    rows.push_back('{KIND_DIV, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1, 0, '0});
    rows.push_back('{KIND_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     0, '0});
    rows.push_back('{KIND_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     0, '0});
    rows.push_back('{KIND_EQ,  32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     0, '0});
    rows.push_back('{KIND_EQ,  32'hFFFF_FFFF, 32'd2, 32'd1, 32'hFFFF_FFFE, 0, '0});
    rows.push_back('{KIND_MUL, 32'h0001_0000, 32'd3, 32'h0001_0000, 32'd5, 0, '0});

    // Release reset at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      row = rows[i];
      if (!row.typed) row.res = predict_fraction(row.kind, row.ln, row.ld, row.rn, row.rd);
      send_item(row.kind, row.ln, row.ld, row.rn, row.rd, row.res);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Hold off once until the unit has drained.
      if (i == RANDOM_ITEMS / 2) begin
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) :
                                            3'($urandom_range(0, 4));
      foreach (p[j]) p[j] = rand_part();
      send_item(kind, p[0], p[1], p[2], p[3], predict_fraction(kind, p[0], p[1], p[2], p[3]));
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("rational_arithmetic_unit test passed");
    end else begin
      $display("rational_arithmetic_unit test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/rau_pkg.sv
src/rau_div.sv
src/rau_mul.sv
src/rational_arithmetic_unit.sv
verif/tb_rational_arithmetic_unit.sv
